// ===== rtl/htwd_pkg.sv =====
// ----------------------------------------------------------------------------
// htwd_pkg
// Types and constants shared by the Huffman tree-walk decoder modules.
// ----------------------------------------------------------------------------
package htwd_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int CNT_W          = 4;
  localparam int BYTE_BITS      = 8;
  localparam int NODE_COUNT_DEF = 512;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic             leaf_flag;
    logic [SYM_W-1:0] leaf_symbol;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } result_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             leaf;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] left;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic begin_decode;
    logic fetch;
    logic step;
    logic check;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic leaf;
    logic bits_zero;
    logic bits_one;
  } dp_status_t;

endpackage

// ===== rtl/htwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// htwd_ctrl
// Sequencer for the tree walk: node fetch, branch, child check, flush.
// ----------------------------------------------------------------------------
module htwd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   mode,
  input  htwd_pkg::dp_status_t   status,
  output htwd_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);
  import htwd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && mode == MODE_DECODE) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = status.bits_zero ? ST_FLUSH : ST_STEP;
      end
      ST_STEP: begin
        state_next = status.leaf ? ST_FETCH : ST_CHECK;
      end
      ST_CHECK: begin
        if (status.leaf) state_next = ST_FETCH;
        else if (status.bits_one) state_next = ST_FLUSH;
        else state_next = ST_STEP;
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy             = 1'b0;
        cmd.load         = start && mode == MODE_LOAD;
        cmd.begin_decode = start && mode == MODE_DECODE;
      end
      ST_FETCH: cmd.fetch = !status.bits_zero;
      ST_STEP:  cmd.step  = 1'b1;
      ST_CHECK: cmd.check = 1'b1;
      ST_FLUSH: cmd.flush = 1'b1;
      default:  busy      = 1'b1;
    endcase
  end

endmodule

// ===== rtl/htwd_datapath.sv =====
// ----------------------------------------------------------------------------
// htwd_datapath
// Node table, walk position, code bit shifter and result holding register.
// ----------------------------------------------------------------------------
module htwd_datapath #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  htwd_pkg::in_item_t            item,
  input  logic                          root_we,
  input  logic [htwd_pkg::IDX_W-1:0]    root_data,
  input  htwd_pkg::ctrl_cmd_t           cmd,
  output htwd_pkg::dp_status_t          status,
  output htwd_pkg::result_t             result,
  output logic                          result_valid
);
  import htwd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [IDX_W:0] IDX_LIM = (IDX_W+1)'(NODE_COUNT);

  node_t            mem [NODE_COUNT];
  node_t            rd_node;
  logic             rd_ok;
  node_t            here;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_addr_ok;
  logic             wr_ok;
  node_t            wr_node;

  logic [IDX_W-1:0] root_node;
  logic [IDX_W-1:0] current_node;
  logic [IDX_W-1:0] next_node;
  logic [7:0]       shreg;
  logic [CNT_W-1:0] bits_left;
  logic [CNT_W-1:0] cnt_sat;
  logic [SYM_W-1:0] pend_sym;
  logic             pend_valid;
  logic             consume;
  logic             hit_leaf;

  assign here       = rd_ok ? rd_node : '0;
  assign rd_en      = cmd.fetch || (cmd.step && !here.leaf);
  assign rd_addr    = cmd.fetch ? current_node : (shreg[7] ? here.right : here.left);
  assign rd_addr_ok = {1'b0, rd_addr} < IDX_LIM;
  assign wr_ok      = {1'b0, item.node_index} < IDX_LIM;
  assign wr_node    = '{symbol: item.leaf_symbol, leaf: item.leaf_flag,
                        right: item.right_child, left: item.left_child};
  assign consume    = (cmd.step && here.leaf) || cmd.check;
  assign hit_leaf   = cmd.check && here.leaf;
  assign cnt_sat    = (item.bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS)
                                                         : item.bit_count;

  assign status.leaf      = here.leaf;
  assign status.bits_zero = bits_left == '0;
  assign status.bits_one  = bits_left == CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      mem[item.node_index[AW-1:0]] <= wr_node;
    end
    if (rd_en && rd_addr_ok) begin
      rd_node <= mem[rd_addr[AW-1:0]];
    end
    if (rd_en) begin
      rd_ok <= rd_addr_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node    <= '0;
      current_node <= '0;
    end else begin
      if (root_we) begin
        root_node    <= root_data;
        current_node <= root_data;
      end else if (cmd.load || (cmd.step && here.leaf) || hit_leaf) begin
        current_node <= root_node;
      end else if (cmd.check) begin
        current_node <= next_node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      next_node <= rd_addr;
    end
    if (cmd.begin_decode) begin
      shreg     <= item.data_byte << (CNT_W'(BYTE_BITS) - cnt_sat);
      bits_left <= cnt_sat;
    end else if (consume) begin
      shreg     <= {shreg[6:0], 1'b0};
      bits_left <= bits_left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (hit_leaf || cmd.flush) && pend_valid;
      if (hit_leaf) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_leaf) begin
      pend_sym <= here.symbol;
    end
    if (hit_leaf || cmd.flush) begin
      result.symbol      <= pend_sym;
      result.last_symbol <= cmd.flush;
    end
  end

endmodule

// ===== rtl/huffman_tree_walk_decoder.sv =====
// A load leaves busy low. A decode byte holds busy while the walk steps and checks each
// code bit and fetches the root node again after each symbol (at most one node table read
// per fetch or step), then flushes; the last result is strobed once busy is low again.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous reset clears control state, root_node and the walk position;
// the node table is undefined until loaded.
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Bit-serial Huffman decoder walking a node table loaded through the item port.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  htwd_pkg::in_item_t          item,
  input  logic                        root_we,
  input  logic [htwd_pkg::IDX_W-1:0]  root_data,
  output htwd_pkg::result_t           result,
  output logic                        result_valid
);
  import htwd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  htwd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (item.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  htwd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .root_we      (root_we),
    .root_data    (root_data),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== rtl/htwd_checker.sv =====
// ----------------------------------------------------------------------------
// htwd_checker
// Port-level checks on transfer timing of the decoder.
// ----------------------------------------------------------------------------
module htwd_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input htwd_pkg::in_item_t  item,
  input htwd_pkg::result_t   result,
  input logic                result_valid
);
  import htwd_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !result_valid)
    else $error("decoder not idle after reset");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode == MODE_LOAD |=> !busy)
    else $error("load transfer kept decoder busy");

  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode == MODE_DECODE |=> busy)
    else $error("decode transfer did not start work");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_symbol |-> busy)
    else $error("non-final result while idle");

  a_last_after_work: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_symbol |-> $past(busy))
    else $error("final result without preceding work");

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result       (result),
  .result_valid (result_valid)
);

// ===== tb/huffman_walk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_walk_checker
// Watches the item, root and result channels of the tree-walk decoder. It keeps
// a shadow node table and walk position, predicts the symbols that each decode
// transfer produces, and compares every strobed result with the oldest one due.
// ----------------------------------------------------------------------------
module huffman_walk_checker #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  htwd_pkg::in_item_t         item,
  input  logic                       root_we,
  input  logic [htwd_pkg::IDX_W-1:0] root_data,
  input  htwd_pkg::result_t          result,
  input  logic                       result_valid,
  output int                         fail_count,
  output int                         pending_count
);
  import htwd_pkg::*;

  node_t            walk_table [NODE_COUNT];
  logic [IDX_W-1:0] walk_root;
  logic [IDX_W-1:0] walk_pos;
  result_t          expected_symbols [$];
  int               fails = 0;
  int               pending = 0;

  assign fail_count    = fails;
  assign pending_count = pending;

  task automatic note_mismatch(input string what, input logic [SYM_W-1:0] got,
                               input logic [SYM_W-1:0] want);
    $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
    fails++;
  endtask

  function automatic node_t fetch_node(input logic [IDX_W-1:0] idx);
    if (int'(idx) >= NODE_COUNT) begin
      return '0;
    end
    return walk_table[idx];
  endfunction

  task automatic predict_decode(input logic [7:0] data, input logic [CNT_W-1:0] cnt);
    result_t          found [BYTE_BITS];
    int               n;
    int               bits;
    node_t            here;
    node_t            nxt;
    logic [IDX_W-1:0] step_to;
    n = 0;
    bits = (cnt > BYTE_BITS) ? BYTE_BITS : int'(cnt);
    for (int i = bits - 1; i >= 0; i--) begin
      here = fetch_node(walk_pos);
      if (here.leaf) begin
        // leaf under the walk: bit is swallowed, back to root
        walk_pos = walk_root;
      end else begin
        step_to = data[i] ? here.right : here.left;
        nxt = fetch_node(step_to);
        if (nxt.leaf) begin
          found[n].symbol = nxt.symbol;
          found[n].last_symbol = 1'b0;
          n++;
          walk_pos = walk_root;
        end else begin
          walk_pos = step_to;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) begin
        found[k].last_symbol = 1'b1;
      end
      expected_symbols = {expected_symbols, found[k]};
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    node_t   loaded;
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        walk_table[i] = '0;
      end
      walk_root = '0;
      walk_pos = '0;
      expected_symbols.delete();
    end else begin
      if (result_valid) begin
        if (expected_symbols.size() == 0) begin
          note_mismatch("unexpected result", result.symbol, '0);
        end else begin
          want = expected_symbols.pop_front();
          if (result.symbol !== want.symbol) begin
            note_mismatch("symbol", result.symbol, want.symbol);
          end
          if (result.last_symbol !== want.last_symbol) begin
            note_mismatch("last_symbol", SYM_W'(result.last_symbol),
                          SYM_W'(want.last_symbol));
          end
        end
      end
      if (start && !busy) begin
        if (item.mode == MODE_LOAD) begin
          loaded.symbol = item.leaf_symbol;
          loaded.leaf = item.leaf_flag;
          loaded.right = item.right_child;
          loaded.left = item.left_child;
          if (int'(item.node_index) < NODE_COUNT) begin
            walk_table[item.node_index] = loaded;
          end
          walk_pos = walk_root;
        end else begin
          predict_decode(item.data_byte, item.bit_count);
        end
      end
      if (root_we) begin
        walk_root = root_data;
        walk_pos = root_data;
      end
    end
    pending <= expected_symbols.size();
  end

endmodule

// ===== tb/huffman_tree_walk_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_test
// Loads random full code trees at random table indexes, points the root at
// them and decodes random byte streams, with directed cases for saturated and
// zero bit counts, codes spanning bytes, loads in mid-code and leaf roots.
// A side checker predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_test;
  import htwd_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int ITEM_TARGET   = 350;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  in_item_t         item;
  logic             root_we;
  logic [IDX_W-1:0] root_data;
  result_t          result;
  logic             result_valid;
  int               fail_count;
  int               pending_count;

  int               idle_pct;
  int               items_sent;
  int               quiet_cycles = 0;
  bit               node_loaded [NODE_COUNT_DEF];
  bit               in_tree [NODE_COUNT_DEF];
  logic [IDX_W-1:0] loaded_nodes [$];
  logic [IDX_W-1:0] tree_root;
  int               phase_idle [4] = '{0, 53, 0, 28};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  huffman_tree_walk_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .root_we      (root_we),
    .root_data    (root_data),
    .result       (result),
    .result_valid (result_valid)
  );

  huffman_walk_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .root_we       (root_we),
    .root_data     (root_data),
    .result        (result),
    .result_valid  (result_valid),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || root_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode = 1'($urandom_range(1));
    it.node_index = IDX_W'($urandom_range(511));
    it.left_child = IDX_W'($urandom_range(511));
    it.right_child = IDX_W'($urandom_range(511));
    it.leaf_flag = 1'($urandom_range(1));
    it.leaf_symbol = SYM_W'($urandom_range(255));
    it.data_byte = 8'($urandom_range(255));
    it.bit_count = CNT_W'($urandom_range(15));
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    logic [IDX_W-1:0] p;
    p = IDX_W'($urandom_range(511));
    for (int t = 0; t < 16 && in_tree[p]; t++) begin
      p = IDX_W'($urandom_range(511));
    end
    in_tree[p] = 1'b1;
    return p;
  endfunction

  task automatic issue(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] lc,
                           input logic [IDX_W-1:0] rc, input logic lf,
                           input logic [SYM_W-1:0] sym);
    in_item_t it;
    it = random_item();
    it.mode = MODE_LOAD;
    it.node_index = idx;
    it.left_child = lc;
    it.right_child = rc;
    it.leaf_flag = lf;
    it.leaf_symbol = sym;
    issue(it);
    if (!node_loaded[idx]) begin
      node_loaded[idx] = 1'b1;
      loaded_nodes = {loaded_nodes, idx};
    end
  endtask

  task automatic decode_byte(input logic [7:0] data, input logic [CNT_W-1:0] cnt);
    in_item_t it;
    it = random_item();
    it.mode = MODE_DECODE;
    it.data_byte = data;
    it.bit_count = cnt;
    issue(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] r);
    drain();
    root_we <= 1'b1;
    root_data <= r;
    @(posedge clk);
    root_we <= 1'b0;
  endtask

  // children are loaded before parents, so every walk stays on loaded entries
  task automatic build_tree(input int n_leaves);
    logic [IDX_W-1:0] pool [$];
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [IDX_W-1:0] p;
    int               a;
    for (int i = 0; i < NODE_COUNT_DEF; i++) begin
      in_tree[i] = 1'b0;
    end
    for (int i = 0; i < n_leaves; i++) begin
      p = pick_index();
      load_node(p, IDX_W'($urandom_range(511)), IDX_W'($urandom_range(511)), 1'b1,
                SYM_W'($urandom_range(255)));
      pool = {pool, p};
    end
    while (pool.size() > 1) begin
      a = $urandom_range(pool.size() - 1);
      x = pool[a];
      pool.delete(a);
      a = $urandom_range(pool.size() - 1);
      y = pool[a];
      pool.delete(a);
      p = pick_index();
      load_node(p, x, y, 1'b0, SYM_W'($urandom_range(255)));
      pool = {pool, p};
    end
    tree_root = pool[0];
  endtask

  initial begin
    int       phase;
    int       r;
    int       n_leaves;
    in_item_t noise;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    root_we = 1'b0;
    root_data = '0;
    idle_pct = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // codes: 0 -> 00, 10 -> 00, 11 -> ff, rooted at node 0
    load_node(9'h1FF, 9'h1FF, 9'h1FF, 1'b1, 8'hFF);
    load_node(9'h001, 9'h000, 9'h000, 1'b1, 8'h00);
    load_node(9'h002, 9'h001, 9'h1FF, 1'b0, 8'h5A);
    load_node(9'h000, 9'h001, 9'h002, 1'b0, 8'hA5);
    decode_byte(8'h00, 4'd8);
    decode_byte(8'hFF, 4'd8);
    decode_byte(8'hA5, 4'd15);
    decode_byte(8'h3C, 4'd0);
    decode_byte(8'h01, 4'd1);
    decode_byte(8'h01, 4'd1);
    // load in mid-code restarts the walk
    decode_byte(8'h01, 4'd1);
    load_node(9'h003, 9'h1FF, 9'h1FF, 1'b1, 8'h3C);
    decode_byte(8'h01, 4'd1);
    decode_byte(8'h00, 4'd1);
    decode_byte(8'h5B, 4'd9);
    write_root(9'h1FF);
    decode_byte(8'hFF, 4'd8);
    decode_byte(8'h00, 4'd8);
    write_root(9'h002);
    decode_byte(8'h6D, 4'd8);
    write_root(9'h000);
    decode_byte(8'hC3, 4'd8);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      // receiver cannot stall, so only the driver idles, as often as phase_idle sets per phase
      idle_pct = phase_idle[phase % 4];
      phase++;
      r = $urandom_range(99);
      if (r < 10) begin
        n_leaves = 1;
      end else if (r < 80) begin
        n_leaves = $urandom_range(2, 8);
      end else begin
        n_leaves = $urandom_range(9, 24);
      end
      build_tree(n_leaves);
      write_root(tree_root);
      repeat ($urandom_range(3, 12)) begin
        r = $urandom_range(99);
        if (r < 8) begin
          noise = random_item();
          noise.mode = MODE_LOAD;
          if (!noise.leaf_flag) begin
            noise.left_child = loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
            noise.right_child = loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
          end
          load_node(noise.node_index, noise.left_child, noise.right_child,
                    noise.leaf_flag, noise.leaf_symbol);
        end else if (r < 18) begin
          decode_byte(8'($urandom_range(255)), CNT_W'($urandom_range(15)));
        end else if (r < 26) begin
          decode_byte(8'($urandom_range(255)), CNT_W'($urandom_range(1, 8)));
        end else begin
          decode_byte(8'($urandom_range(255)), CNT_W'(BYTE_BITS));
        end
      end
    end

    drain();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
